>>> src/tmx_pkg.sv
// ----------------------------------------------------------------------------
// tmx_pkg - shared types and constants of the tape machine execute unit
// Opcode encoding, tape geometry and input byte mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package tmx_pkg;

  // Tape geometry. The head wraps by dropping carry bits, so the cell count
  // is a power of two.
  localparam int unsigned TapeCells = 32768;
  localparam int unsigned HeadW     = $clog2(TapeCells);

  typedef logic [HeadW-1:0] head_t;
  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      index_t;

  typedef enum logic [2:0] {
    KIND_RIGHT  = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_INCR   = 3'd2,
    KIND_DECR   = 3'd3,
    KIND_OUT    = 3'd4,
    KIND_IN     = 3'd5,
    KIND_LBEGIN = 3'd6,
    KIND_LEND   = 3'd7
  } kind_e;

  localparam byte_t CrByte  = 8'd13;
  localparam byte_t LfByte  = 8'd10;
  localparam byte_t EofByte = 8'd26;

  // Carriage return becomes newline; end of input and the EOF byte store zero.
  function automatic byte_t map_input(byte_t b, logic ended);
    byte_t r;
    r = b;
    if (ended) begin
      r = '0;
    end else if (b == CrByte) begin
      r = LfByte;
    end else if (b == EofByte) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tape_machine_instruction_exec_unit.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_exec_unit - execute stage of a tape machine
// Byte-cell tape in a synchronous RAM, head pointer, run-length opcodes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one decoded instruction
//   per transfer: kind, amount, partner_index, in_byte, in_end.
//   Result channel (res_valid_o / res_stall_i) carries exactly one result
//   per instruction, in order: out_valid/out_byte for output instructions,
//   jump_taken/jump_target for loop instructions, zero elsewhere.
//   An instruction passes stage 1 (RAM read), then the result register,
//   from which its result is presented and can transfer.
//   Throughput: one instruction per cycle while in_stall_o is low. The tape
//   RAM is read at the head when the instruction is taken and written back
//   when stage 1 advances; the write of the instruction ahead is forwarded
//   when both touch one cell.
//   Reset: head goes to zero and a clearing pass writes zero to every tape
//   cell, one cell per cycle, with in_stall_o held high.
//   Receiver stall: the result register holds; one more instruction can
//   sit in the RAM stage, after which in_stall_o rises until the result
//   transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_machine_instruction_exec_unit (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // instruction channel
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [2:0]            kind_i,
  input  wire  [15:0]           amount_i,
  input  wire  [15:0]           partner_index_i,
  input  wire  [7:0]            in_byte_i,
  input  wire                   in_end_i,
  // result channel
  output logic                  res_valid_o,
  input  wire                   res_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  jump_taken_o,
  output logic [15:0]           jump_target_o
);
  import tmx_pkg::*;

  // ---------------------------------------------------------------- memory
  byte_t tape_mem [TapeCells];
  byte_t rdata_q;
  logic  mem_we;
  head_t mem_waddr;
  byte_t mem_wdata;

  // ---------------------------------------------------------------- control
  logic  clearing_q, clearing_d;
  head_t clr_addr_q, clr_addr_d;
  head_t head_q, head_d;
  logic  in_xfer;

  // stage 1: RAM data returns, cell is modified and written back
  logic   s1_valid_q, s1_valid_d;
  kind_e  s1_kind_q;
  byte_t  s1_amount_q;
  index_t s1_partner_q;
  byte_t  s1_inbyte_q;
  head_t  s1_addr_q;
  logic   s1_adv;

  // last write, forwarded to the instruction read under it
  logic  fwd_valid_q, fwd_valid_d;
  head_t fwd_addr_q;
  byte_t fwd_data_q;

  // result register
  logic   res_valid_q, res_valid_d;
  logic   res_out_q;
  byte_t  res_byte_q;
  logic   res_jump_q;
  index_t res_target_q;

  byte_t  cur_cell;
  byte_t  new_cell;
  logic   cell_wr;
  logic   r_out, r_jump;
  byte_t  r_byte;
  index_t r_target;
  head_t  step;

  // ---------------------------------------------------------------- handshake
  assign s1_adv     = !res_valid_q || !res_stall_i;
  assign in_stall_o = clearing_q || (s1_valid_q && !s1_adv);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- head
  assign step = head_t'(amount_i);

  always_comb begin
    head_d = head_q;
    if (in_xfer) begin
      unique case (kind_e'(kind_i))
        KIND_RIGHT: head_d = head_q + step;
        KIND_LEFT:  head_d = head_q - step;
        default:    head_d = head_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- clearing
  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == head_t'(TapeCells - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Forwarded write is the latest one, so it always matches RAM content.
  assign cur_cell = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rdata_q;

  always_comb begin
    new_cell = cur_cell;
    cell_wr  = 1'b0;
    r_out    = 1'b0;
    r_byte   = '0;
    r_jump   = 1'b0;
    r_target = '0;
    unique case (s1_kind_q)
      KIND_INCR: begin
        new_cell = cur_cell + s1_amount_q;
        cell_wr  = 1'b1;
      end
      KIND_DECR: begin
        new_cell = cur_cell - s1_amount_q;
        cell_wr  = 1'b1;
      end
      KIND_IN: begin
        new_cell = s1_inbyte_q;
        cell_wr  = 1'b1;
      end
      KIND_OUT: begin
        r_out  = 1'b1;
        r_byte = cur_cell;
      end
      KIND_LBEGIN: begin
        if (cur_cell == '0) begin
          r_jump   = 1'b1;
          r_target = s1_partner_q;
        end
      end
      KIND_LEND: begin
        if (cur_cell != '0) begin
          r_jump   = 1'b1;
          r_target = s1_partner_q;
        end
      end
      default: begin
        // moves: no cell access
      end
    endcase
  end

  // write port: clearing pass, else write-back on stage 1 advance
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_q;
    mem_wdata = new_cell;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (s1_valid_q && s1_adv && cell_wr) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    fwd_valid_d = fwd_valid_q;
    if (s1_valid_q && s1_adv && cell_wr) begin
      fwd_valid_d = 1'b1;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (s1_adv) begin
      res_valid_d = s1_valid_q;
    end
  end

  // ---------------------------------------------------------------- RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tape_mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rdata_q <= tape_mem[head_q];
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      head_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_addr_q  <= clr_addr_d;
      head_q      <= head_d;
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= fwd_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q    <= kind_e'(kind_i);
      s1_amount_q  <= amount_i[7:0];
      s1_partner_q <= partner_index_i;
      s1_inbyte_q  <= map_input(in_byte_i, in_end_i);
      s1_addr_q    <= head_q;
    end
    if (s1_valid_q && s1_adv && cell_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= new_cell;
    end
    if (s1_valid_q && s1_adv) begin
      res_out_q    <= r_out;
      res_byte_q   <= r_byte;
      res_jump_q   <= r_jump;
      res_target_q <= r_target;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = res_out_q;
  assign out_byte_o    = res_byte_q;
  assign jump_taken_o  = res_jump_q;
  assign jump_target_o = res_target_q;

endmodule

`default_nettype wire

>>> src/tmx_checker.sv
// ----------------------------------------------------------------------------
// tmx_checker - port-level checks of the tape machine execute unit
// Result field consistency and result channel hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tmx_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        res_valid_o,
  input wire        res_stall_i,
  input wire        out_valid_o,
  input wire [7:0]  out_byte_o,
  input wire        jump_taken_o,
  input wire [15:0] jump_target_o
);

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(out_valid_o)
      && $stable(out_byte_o) && $stable(jump_taken_o) && $stable(jump_target_o))
    else $error("result changed while stalled");

  // an instruction is either output or loop, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(out_valid_o && jump_taken_o))
    else $error("output and jump in one result");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("out_byte nonzero without out_valid");

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !jump_taken_o |-> jump_target_o == 16'd0)
    else $error("jump_target nonzero without jump");

  // no result can appear without an instruction taken earlier and passed through stage 1
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without instruction");

endmodule

bind tape_machine_instruction_exec_unit tmx_checker u_tmx_checker (.*);

`default_nettype wire
